/* src/key_click_long_press_detector_core_defines.svh */
// Assertion macros for the key click / long-press detector.
// No dependencies; included by the checker module.
`ifndef KEY_CLICK_LONG_PRESS_DETECTOR_CORE_DEFINES_SVH
`define KEY_CLICK_LONG_PRESS_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define KCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define KCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/kcd_pkg.sv */
// Shared types and constants of the key click / long-press detector.
// No dependencies; used by every other file except the assertion macro header.
package kcd_pkg;

  localparam int unsigned NUM_KEYS  = 16;
  localparam int unsigned KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned EVT_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [TIME_W-1:0] TICKS_RESET = 32'd500;
  localparam logic [MASK_W-1:0] MASK_RESET  = '0;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS_TICKS  = 1'd0,
    CFG_EVENT_ENABLE_MASK = 1'd1
  } kcd_cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_RELEASE = 2'd0,
    CLS_CLICK   = 2'd1,
    CLS_LONG    = 2'd2
  } kcd_class_e;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } kcd_event_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic              key_level;
    logic [TIME_W-1:0] time_now;
    logic              key_ok;
    logic              enabled;
  } kcd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kcd_fifo_stat_t;

  typedef struct packed {
    logic [KEY_W-1:0] report_key;
    kcd_event_e       press_event;
    logic             release_event;
    logic             rising_edge;
    logic             falling_edge;
    logic             long_press_state;
  } kcd_result_t;

endpackage

/* src/kcd_in_if.sv */
// Input channel of the detector: valid/ready plus one key sample.
// Depends on kcd_pkg.
interface kcd_in_if;
  import kcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_id;
  logic              key_level;
  logic [TIME_W-1:0] time_now;

  modport source (output valid, key_id, key_level, time_now, input ready);
  modport sink (input valid, key_id, key_level, time_now, output ready);
endinterface

/* src/kcd_out_if.sv */
// Output channel of the detector: valid/ready plus one key report.
// Depends on kcd_pkg.
interface kcd_out_if;
  import kcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] report_key;
  logic [EVT_W-1:0] press_event;
  logic             release_event;
  logic             rising_edge;
  logic             falling_edge;
  logic             long_press_state;

  modport source (output valid, report_key, press_event, release_event, rising_edge,
                  falling_edge, long_press_state, input ready);
  modport sink (input valid, report_key, press_event, release_event, rising_edge,
                falling_edge, long_press_state, output ready);
endinterface

/* src/kcd_fifo.sv */
// Two-entry queue between the front and back parts of the detector.
// Depends on kcd_pkg.
module kcd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kcd_pkg::kcd_item_t  push_item_i,
  input  logic                pop_i,
  output kcd_pkg::kcd_item_t  pop_item_o,
  output kcd_pkg::kcd_fifo_stat_t stat_o
);
  import kcd_pkg::*;

  kcd_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end
endmodule

/* src/kcd_front.sv */
// Front part: configuration registers, input transfer and key range/enable lookup.
// Depends on kcd_pkg and kcd_in_if.
module kcd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kcd_pkg::CFG_W-1:0]  cfg_wdata_i,
  kcd_in_if.sink                     in_ch,
  input  kcd_pkg::kcd_fifo_stat_t    fifo_stat_i,
  output logic                       push_o,
  output kcd_pkg::kcd_item_t         push_item_o,
  output logic [kcd_pkg::TIME_W-1:0] ticks_o
);
  import kcd_pkg::*;

  logic [TIME_W-1:0] ticks_q;
  logic [MASK_W-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
      mask_q  <= MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (kcd_cfg_idx_e'(cfg_idx_i))
        CFG_LONG_PRESS_TICKS:  ticks_q <= cfg_wdata_i[TIME_W-1:0];
        CFG_EVENT_ENABLE_MASK: mask_q  <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign ticks_o     = ticks_q;
  assign in_ch.ready = !fifo_stat_i.full;
  assign push_o      = in_ch.valid && !fifo_stat_i.full;

  always_comb begin
    push_item_o.key_id    = in_ch.key_id;
    push_item_o.key_level = in_ch.key_level;
    push_item_o.time_now  = in_ch.time_now;
    push_item_o.key_ok    = (32'(in_ch.key_id) < 32'(NUM_KEYS));
    push_item_o.enabled   = mask_q[in_ch.key_id];
  end
endmodule

/* src/kcd_back.sv */
// Back part: per-key state read-modify-write and the output register.
// Depends on kcd_pkg and kcd_out_if.
module kcd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [kcd_pkg::TIME_W-1:0] ticks_i,
  input  kcd_pkg::kcd_item_t         item_i,
  input  kcd_pkg::kcd_fifo_stat_t    fifo_stat_i,
  output logic                       pop_o,
  kcd_out_if.source                  out_ch
);
  import kcd_pkg::*;

  logic              level_q [NUM_KEYS];
  logic [TIME_W-1:0] press_time_q [NUM_KEYS];
  kcd_class_e        class_q [NUM_KEYS];

  logic              out_valid_q;
  kcd_result_t       res_q, res_d;

  logic [KEY_IDX_W-1:0] sel;
  logic              last, rise, fall, is_long;
  logic [TIME_W-1:0] hold;
  kcd_class_e        cls, cls_fin;

  assign pop_o = !fifo_stat_i.empty && (!out_valid_q || out_ch.ready);
  assign sel   = item_i.key_id[KEY_IDX_W-1:0];

  always_comb begin
    last    = level_q[sel];
    rise    = item_i.key_level && !last;
    fall    = !item_i.key_level && last;
    hold    = item_i.time_now - (rise ? item_i.time_now : press_time_q[sel]);
    is_long = (hold >= ticks_i);
    cls     = class_q[sel];
    if (rise) cls = CLS_CLICK;
    if (fall) cls = is_long ? CLS_LONG : CLS_CLICK;
    if (item_i.key_level && is_long) cls = CLS_LONG;
    cls_fin = item_i.key_level ? cls : CLS_RELEASE;

    res_d                  = '0;
    res_d.report_key       = item_i.key_id;
    res_d.press_event      = EV_NONE;
    if (item_i.key_ok) begin
      if (item_i.enabled) begin
        if (rise) res_d.press_event = EV_CLICK;
        else if (cls == CLS_LONG) res_d.press_event = EV_LONG;
        res_d.release_event = fall;
      end
      res_d.rising_edge      = rise;
      res_d.falling_edge     = fall;
      res_d.long_press_state = (cls_fin == CLS_LONG);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        level_q[k]      <= 1'b0;
        press_time_q[k] <= '0;
        class_q[k]      <= CLS_RELEASE;
      end
    end else begin
      if (pop_o) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
      if (pop_o && item_i.key_ok) begin
        level_q[sel] <= item_i.key_level;
        class_q[sel] <= cls_fin;
        if (rise) press_time_q[sel] <= item_i.time_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.report_key       = res_q.report_key;
  assign out_ch.press_event      = res_q.press_event;
  assign out_ch.release_event    = res_q.release_event;
  assign out_ch.rising_edge      = res_q.rising_edge;
  assign out_ch.falling_edge     = res_q.falling_edge;
  assign out_ch.long_press_state = res_q.long_press_state;
endmodule

/* src/key_click_long_press_detector_core.sv */
// Key click / long-press detector. Takes one key sample per transfer and returns
// one report per sample, in order. Sustained rate is one sample per clock while the
// report channel is ready; each sample is written to the queue, then popped by the
// per-key state read-modify-write in the back part, which also loads the output
// register. The two-entry queue holds up to two samples while a report waits.
// Hold time is (time_now - press time) mod 2^32 against long_press_ticks.
// Depends on kcd_pkg, kcd_in_if, kcd_out_if, kcd_front, kcd_fifo, kcd_back.
module key_click_long_press_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kcd_pkg::CFG_W-1:0]     cfg_wdata_i,
  kcd_in_if.sink                        in_i,
  kcd_out_if.source                     out_o
);
  import kcd_pkg::*;

  logic              push, pop;
  kcd_item_t         push_item, pop_item;
  kcd_fifo_stat_t    fifo_stat;
  logic [TIME_W-1:0] ticks;

  kcd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_ch       (in_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_item_o (push_item),
    .ticks_o     (ticks)
  );

  kcd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (fifo_stat)
  );

  kcd_back u_back (
    .clk_i,
    .rst_ni,
    .ticks_i     (ticks),
    .item_i      (pop_item),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_ch      (out_o)
  );
endmodule

/* src/kcd_checker.sv */
// Port-level checks of the detector's report channel, bound to the top level.
// Depends on kcd_pkg and key_click_long_press_detector_core_defines.svh.
`include "key_click_long_press_detector_core_defines.svh"

module kcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [kcd_pkg::KEY_W-1:0]    report_key_i,
  input logic [kcd_pkg::EVT_W-1:0]    press_event_i,
  input logic                         release_event_i,
  input logic                         rising_edge_i,
  input logic                         falling_edge_i,
  input logic                         long_press_state_i
);
  import kcd_pkg::*;

  `KCD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(report_key_i) && $stable(press_event_i), "report changed while stalled")
  `KCD_ASSERT_NOW(a_edges_excl, out_valid_i, !(rising_edge_i && falling_edge_i), "both edges flagged")
  `KCD_ASSERT_NOW(a_release_on_fall, out_valid_i && release_event_i, falling_edge_i, "release event without falling edge")
  `KCD_ASSERT_NOW(a_long_held, out_valid_i && long_press_state_i, !falling_edge_i && (press_event_i != EVT_W'(EV_CLICK) || rising_edge_i), "long state on released key or click without press")
endmodule

bind key_click_long_press_detector_core kcd_checker u_kcd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .report_key_i       (out_o.report_key),
  .press_event_i      (out_o.press_event),
  .release_event_i    (out_o.release_event),
  .rising_edge_i      (out_o.rising_edge),
  .falling_edge_i     (out_o.falling_edge),
  .long_press_state_i (out_o.long_press_state)
);

/* bench/tb_key_click_long_press_detector_core.sv */
// Self-checking bench for key_click_long_press_detector_core: directed and random key samples,
// each report checked in order against a per-key click/long-press predictor.
// Depends on kcd_pkg, kcd_in_if, kcd_out_if and the core itself.
module tb_key_click_long_press_detector_core;
  import kcd_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              pressed;
    logic [TIME_W-1:0] stamp;
  } key_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  kcd_in_if  in_if ();
  kcd_out_if out_if ();

  key_click_long_press_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the block's registers and per-key state
  logic [TIME_W-1:0] hold_limit = TICKS_RESET;
  logic [MASK_W-1:0] enable_mask = MASK_RESET;
  logic              key_down [NUM_KEYS];
  logic [TIME_W-1:0] press_stamp [NUM_KEYS];
  kcd_class_e        key_class [NUM_KEYS];

  key_sample_t sample_q [$];
  kcd_result_t report_due_q [$];
  int unsigned bad_cnt = 0;

  int unsigned in_gap;
  bit          in_steady = 1'b0;
  int unsigned out_stall = 0;
  bit          out_steady = 1'b0;

  function automatic kcd_result_t classify_sample(logic [KEY_W-1:0] id, logic now_down,
                                                  logic [TIME_W-1:0] stamp);
    kcd_result_t       rep;
    logic              was_down;
    logic              rise;
    logic              fall;
    logic [TIME_W-1:0] held;
    kcd_class_e        cls;
    rep = '0;
    rep.report_key = id;
    was_down = key_down[id];
    key_down[id] = now_down;
    rise = now_down & ~was_down;
    fall = ~now_down & was_down;
    cls = key_class[id];
    if (rise) begin
      press_stamp[id] = stamp;
      cls = CLS_CLICK;
    end
    held = stamp - press_stamp[id];
    if (fall) cls = (held >= hold_limit) ? CLS_LONG : CLS_CLICK;
    if (now_down && held >= hold_limit) cls = CLS_LONG;
    rep.press_event = EV_NONE;
    if (enable_mask[id]) begin
      if (rise) rep.press_event = EV_CLICK;
      else if (cls == CLS_LONG) rep.press_event = EV_LONG;
      rep.release_event = fall;
    end
    if (!now_down) cls = CLS_RELEASE;
    key_class[id] = cls;
    rep.rising_edge = rise;
    rep.falling_edge = fall;
    rep.long_press_state = (cls == CLS_LONG);
    return rep;
  endfunction

  // sample driver
  always @(posedge clk_i) begin : drive
    key_sample_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        report_due_q.push_back(classify_sample(in_if.key_id, in_if.key_level, in_if.time_now));
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_if.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.key_id <= nxt.key;
          in_if.key_level <= nxt.pressed;
          in_if.time_now <= nxt.stamp;
          if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
          in_gap <= in_steady ? 0 : $urandom_range(0, 4);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk_i) begin : observe
    kcd_result_t got;
    kcd_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b1;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.report_key = out_if.report_key;
        got.press_event = kcd_event_e'(out_if.press_event);
        got.release_event = out_if.release_event;
        got.rising_edge = out_if.rising_edge;
        got.falling_edge = out_if.falling_edge;
        got.long_press_state = out_if.long_press_state;
        if (report_due_q.size() == 0) begin
          if (bad_cnt < 10) $display("unexpected report transfer: key %0d", got.report_key);
          bad_cnt++;
        end else begin
          want = report_due_q.pop_front();
          if (got !== want) begin
            if (bad_cnt < 10)
              $display({"report mismatch: key %0d/%0d press %0d/%0d release %0d/%0d ",
                        "rise %0d/%0d fall %0d/%0d long %0d/%0d (exp/got)"},
                       want.report_key, got.report_key, want.press_event, got.press_event,
                       want.release_event, got.release_event, want.rising_edge,
                       got.rising_edge, want.falling_edge, got.falling_edge,
                       want.long_press_state, got.long_press_state);
            bad_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
        out_stall = out_steady ? 0 : $urandom_range(0, 4);
        out_if.ready <= (out_stall == 0);
      end else if (!out_if.ready) begin
        if (out_stall <= 1) begin
          out_if.ready <= 1'b1;
          out_stall = 0;
        end else begin
          out_stall = out_stall - 1;
        end
      end
    end
  end

  task automatic push_sample(input logic [KEY_W-1:0] key, input logic pressed,
                             input logic [TIME_W-1:0] stamp);
    key_sample_t s;
    s.key = key;
    s.pressed = pressed;
    s.stamp = stamp;
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input kcd_cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LONG_PRESS_TICKS: hold_limit = val;
      CFG_EVENT_ENABLE_MASK: enable_mask = val[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every sample is transferred and every report is back
  task automatic drain();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_if.valid || report_due_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] step_max;
    logic [TIME_W-1:0] lim;
    logic [MASK_W-1:0] msk;
    logic [KEY_W-1:0]  key;
    logic              lvl;
    logic              gen_down [NUM_KEYS];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LONG_PRESS_TICKS;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.key_id = '0;
    in_if.key_level = 1'b0;
    in_if.time_now = '0;
    out_if.ready = 1'b1;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_down[k] = 1'b0;
      press_stamp[k] = '0;
      key_class[k] = CLS_RELEASE;
      gen_down[k] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold, all keys enabled: click, hold, long press, wrap
    write_reg(CFG_EVENT_ENABLE_MASK, 32'h0000_FFFF);
    write_reg(CFG_LONG_PRESS_TICKS, 32'd500);
    push_sample(4'd0, 1'b1, 32'd0);
    push_sample(4'd0, 1'b1, 32'd499);
    push_sample(4'd0, 1'b1, 32'd500);
    push_sample(4'd0, 1'b0, 32'd600);
    push_sample(4'd15, 1'b1, 32'hFFFF_FF00);
    push_sample(4'd15, 1'b0, 32'h0000_0100);
    push_sample(4'd1, 1'b1, 32'd10);
    push_sample(4'd1, 1'b0, 32'd20);
    push_sample(4'd2, 1'b0, 32'd30);
    push_sample(4'd14, 1'b1, 32'h5A5A_A5A5);
    push_sample(4'd14, 1'b0, 32'hA5A5_5A5A);
    drain();

    // disabled keys with a zero threshold
    write_reg(CFG_EVENT_ENABLE_MASK, 32'h0000_0000);
    write_reg(CFG_LONG_PRESS_TICKS, 32'd0);
    push_sample(4'd3, 1'b1, 32'd40);
    push_sample(4'd3, 1'b0, 32'd41);
    drain();

    // zero threshold: the press still reports a click first
    write_reg(CFG_EVENT_ENABLE_MASK, 32'h0000_FFFF);
    push_sample(4'd4, 1'b1, 32'd100);
    push_sample(4'd4, 1'b1, 32'd100);
    push_sample(4'd4, 1'b0, 32'd100);
    drain();

    // maximum threshold
    write_reg(CFG_LONG_PRESS_TICKS, 32'hFFFF_FFFF);
    push_sample(4'd5, 1'b1, 32'd1);
    push_sample(4'd5, 1'b1, 32'hFFFF_FFFF);
    push_sample(4'd5, 1'b1, 32'd0);
    push_sample(4'd5, 1'b0, 32'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: lim = 32'd0;
        1: lim = 32'hFFFF_FFFF;
        2: lim = $urandom_range(1, 64);
        default: lim = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0, 1: msk = 16'hFFFF;
        2, 3: msk = MASK_W'($urandom());
        default: msk = 16'h0000;
      endcase
      write_reg(CFG_LONG_PRESS_TICKS, lim);
      write_reg(CFG_EVENT_ENABLE_MASK, {16'h0000, msk});
      step_max = (lim != 0 && lim <= 32'd4096) ? lim / 16 + 1 : 32'd16;
      stamp = (ph == 1) ? 32'hFFFF_FF00 : $urandom();
      for (int n = 0; n < 300; n++) begin
        key = KEY_W'($urandom_range(0, NUM_KEYS - 1));
        if ($urandom_range(0, 7) == 0) lvl = 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 2) == 0) lvl = !gen_down[key];
        else lvl = gen_down[key];
        gen_down[key] = lvl;
        if ($urandom_range(0, 15) == 0) stamp = stamp + $urandom();
        else stamp = stamp + $urandom_range(0, step_max);
        push_sample(key, lvl, stamp);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (bad_cnt == 0 && report_due_q.size() == 0) begin
      $display("[key_click_long_press_detector_core] OK");
    end else begin
      $display("[key_click_long_press_detector_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[key_click_long_press_detector_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/kcd_pkg.sv
src/kcd_in_if.sv
src/kcd_out_if.sv
src/kcd_fifo.sv
src/kcd_front.sv
src/kcd_back.sv
src/key_click_long_press_detector_core.sv
src/kcd_checker.sv
bench/tb_key_click_long_press_detector_core.sv
